@@ hw/rtl/sws_pkg.sv @@
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and fixed constants of the sliding window sum block.
// ----------------------------------------------------------------------------
package sws_pkg;

    // width of the window length register
    localparam int LEN_W = 11;

    // window length after reset
    localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 11'd20;

    // width of the signed integer sum (Q47.0 plus sign) and of the wider add-subtract result
    localparam int SUM_W = 48;
    localparam int ACC_W = SUM_W + 2;

    // saturation limits of the sum
    localparam logic [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

    // depth of the queues between the parts
    localparam int QUEUE_DEPTH = 4;

    // classification of one item, made by the front end
    typedef struct packed {
        logic present;   // sample is summed and stored
        logic restart;   // sum starts again from zero
        logic subtract;  // oldest sample leaves the window
        logic valid;     // result covers a full window, or window length is zero
    } cmd_t;

endpackage

@@ hw/rtl/sws_queue.sv @@
// ----------------------------------------------------------------------------
// sws_queue
// Small register queue with push/full and pop/empty, one transfer each side
// per cycle, push and pop allowed in the same cycle.
// ----------------------------------------------------------------------------
module sws_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[head_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_rd)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[tail_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/sws_front.sv @@
// ----------------------------------------------------------------------------
// sws_front
// Front end: holds the window length, write pointer and fill count, accepts
// items and classifies each one into a command with its ring addresses.
// ----------------------------------------------------------------------------
module sws_front #(
    parameter int WINDOW_MAX   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               push,
    output logic                               full,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    input  logic                               sample_present,
    input  logic                               restart,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [sws_pkg::LEN_W-1:0]          cfg_wr_data,
    // command queue
    input  logic                               q_full,
    output logic                               q_push,
    output sws_pkg::cmd_t                      q_cmd,
    output logic [$clog2(WINDOW_MAX)-1:0]      q_wr_addr,
    output logic [$clog2(WINDOW_MAX)-1:0]      q_rd_addr,
    output logic [SAMPLE_WIDTH-1:0]            q_sample
);

    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int IW_A = $clog2(2 * WINDOW_MAX);
    localparam int IW   = (IW_A > sws_pkg::LEN_W) ? IW_A : sws_pkg::LEN_W;

    logic [sws_pkg::LEN_W-1:0] window_len_reg;
    logic [AW-1:0]             wp_reg, wp_next;
    logic [sws_pkg::LEN_W-1:0] fill_reg, fill_next;

    logic [IW-1:0]             len_ext, n_eff, wp_ext, fill_ext, rd_wide;
    logic [AW-1:0]             wp_base, wp_inc;
    logic [sws_pkg::LEN_W-1:0] fill_base, fill_after;
    logic                      win_mode, full_win, accept;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign q_push = accept;

    // effective window and ring addresses
    always_comb
    begin
        len_ext    = IW'(window_len_reg);
        n_eff      = (len_ext > IW'(WINDOW_MAX)) ? IW'(WINDOW_MAX) : len_ext;
        wp_base    = restart ? '0 : wp_reg;
        fill_base  = restart ? '0 : fill_reg;
        wp_ext     = IW'(wp_base);
        fill_ext   = IW'(fill_base);
        win_mode   = (n_eff != '0);
        full_win   = win_mode && (fill_ext >= n_eff);
        rd_wide    = (wp_ext >= n_eff) ? wp_ext - n_eff
                                       : wp_ext + IW'(WINDOW_MAX) - n_eff;
        fill_after = (win_mode && !full_win) ? fill_base + 1'b1 : fill_base;
        wp_inc     = (wp_base == AW'(WINDOW_MAX - 1)) ? '0 : wp_base + 1'b1;

        q_cmd.present  = sample_present;
        q_cmd.restart  = restart;
        q_cmd.subtract = sample_present && full_win;
        q_cmd.valid    = sample_present && (!win_mode || IW'(fill_after) >= n_eff);
        q_wr_addr      = wp_base;
        q_rd_addr      = rd_wide[AW-1:0];
        q_sample       = sample;

        wp_next   = sample_present ? wp_inc : wp_base;
        fill_next = sample_present ? fill_after : fill_base;
    end

    // window length, pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= sws_pkg::WINDOW_LEN_RESET;
            wp_reg         <= '0;
            fill_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            window_len_reg <= cfg_wr_data;
            wp_reg         <= '0;
            fill_reg       <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hw/rtl/sws_back.sv @@
// ----------------------------------------------------------------------------
// sws_back
// Back end: reads the leaving sample from the ring, does the saturating
// add-subtract on the running sum, stores the new sample, emits the result.
// ----------------------------------------------------------------------------
module sws_back #(
    parameter int WINDOW_MAX   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    // command queue
    input  logic                               q_empty,
    output logic                               q_pop,
    input  sws_pkg::cmd_t                      q_cmd,
    input  logic [$clog2(WINDOW_MAX)-1:0]      q_wr_addr,
    input  logic [$clog2(WINDOW_MAX)-1:0]      q_rd_addr,
    input  logic [SAMPLE_WIDTH-1:0]            q_sample,
    // result queue
    input  logic                               res_full,
    output logic                               res_push,
    output logic [sws_pkg::SUM_W-1:0]          res_sum,
    output logic                               res_valid
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int ACC_W = sws_pkg::ACC_W;
    localparam int SUM_W = sws_pkg::SUM_W;

    // sample ring
    logic [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;

    // read stage
    logic                    a_valid_reg;
    sws_pkg::cmd_t           a_cmd_reg;
    logic [AW-1:0]           a_wr_addr_reg;
    logic [SAMPLE_WIDTH-1:0] a_sample_reg;
    logic                    a_fwd_reg;
    logic [SAMPLE_WIDTH-1:0] a_fwd_data_reg;

    logic [SUM_W-1:0]        sum_reg;

    logic                    a_done, fwd_hit;
    logic [SAMPLE_WIDTH-1:0] old_sample;
    logic [ACC_W-1:0]        base_ext, new_ext, old_ext, acc;
    logic [SUM_W-1:0]        acc_sat;

    assign a_done   = a_valid_reg && !res_full;
    assign q_pop    = !q_empty && (!a_valid_reg || a_done);
    // the item ahead has not reached the ring yet when it writes the slot read now
    assign fwd_hit  = a_valid_reg && a_cmd_reg.present && (a_wr_addr_reg == q_rd_addr);
    assign res_push = a_done;

    // saturating add-subtract
    always_comb
    begin
        old_sample = a_fwd_reg ? a_fwd_data_reg : rd_data_reg;
        base_ext   = a_cmd_reg.restart ? '0
                                       : {{(ACC_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
        new_ext    = {{(ACC_W-SAMPLE_WIDTH){a_sample_reg[SAMPLE_WIDTH-1]}}, a_sample_reg};
        old_ext    = a_cmd_reg.subtract
                   ? {{(ACC_W-SAMPLE_WIDTH){old_sample[SAMPLE_WIDTH-1]}}, old_sample}
                   : '0;
        acc        = base_ext + new_ext - old_ext;
        if (acc[ACC_W-1:SUM_W-1] == '0 || acc[ACC_W-1:SUM_W-1] == '1)
        begin
            acc_sat = acc[SUM_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            acc_sat = sws_pkg::SUM_LO;
        end
        else
        begin
            acc_sat = sws_pkg::SUM_HI;
        end
        res_sum   = a_cmd_reg.present ? acc_sat : '0;
        res_valid = a_cmd_reg.valid;
    end

    // read stage control and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_done)
            begin
                a_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                sum_reg <= '0;
            end
            else if (a_done && a_cmd_reg.present)
            begin
                sum_reg <= acc_sat;
            end
            else if (a_done && a_cmd_reg.restart)
            begin
                sum_reg <= '0;
            end
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_cmd_reg      <= q_cmd;
            a_wr_addr_reg  <= q_wr_addr;
            a_sample_reg   <= q_sample;
            a_fwd_reg      <= fwd_hit;
            a_fwd_data_reg <= a_sample_reg;
        end
    end

    // ring read and write
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= ring_mem[q_rd_addr];
        end
        if (a_done && a_cmd_reg.present)
        begin
            ring_mem[a_wr_addr_reg] <= a_sample_reg;
        end
    end

endmodule

@@ hw/rtl/sliding_window_sum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_sum
// Path: command queue, read stage and result queue, each registered.
// Throughput: one sample per cycle while no queue is full; the ring memory takes
// one read and one write per cycle and the running sum loop holds one register.
// Reset: window length 20, sum, pointer and fill count cleared, queues empty;
// no clearing pass, a ring read is only used where written in the same series.
// ----------------------------------------------------------------------------
module sliding_window_sum #(
    parameter int WINDOW_MAX   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // samples
    input  logic                               push,
    output logic                               full,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    input  logic                               sample_present,
    input  logic                               restart,
    // results
    output logic                               empty,
    input  logic                               pop,
    output logic signed [sws_pkg::SUM_W-1:0]   window_sum,
    output logic                               result_valid,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [sws_pkg::LEN_W-1:0]          cfg_wr_data
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CMD_W = $bits(sws_pkg::cmd_t);
    localparam int MID_W = CMD_W + 2 * AW + SAMPLE_WIDTH;
    localparam int RES_W = sws_pkg::SUM_W + 1;

    logic                    f_push, mid_full, mid_empty, mid_pop;
    sws_pkg::cmd_t           f_cmd, b_cmd;
    logic [AW-1:0]           f_wr_addr, f_rd_addr, b_wr_addr, b_rd_addr;
    logic [SAMPLE_WIDTH-1:0] f_sample, b_sample;
    logic [MID_W-1:0]        mid_wr_data, mid_rd_data;

    logic                    res_full, res_push, res_valid;
    logic [sws_pkg::SUM_W-1:0] res_sum;
    logic [RES_W-1:0]        res_wr_data, res_rd_data;

    // front end: accept and classify
    sws_front #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .sample         (sample),
        .sample_present (sample_present),
        .restart        (restart),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_full         (mid_full),
        .q_push         (f_push),
        .q_cmd          (f_cmd),
        .q_wr_addr      (f_wr_addr),
        .q_rd_addr      (f_rd_addr),
        .q_sample       (f_sample)
    );

    // command queue between front and back
    assign mid_wr_data = {f_cmd, f_wr_addr, f_rd_addr, f_sample};

    sws_queue #(
        .WIDTH (MID_W),
        .DEPTH (sws_pkg::QUEUE_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (mid_wr_data),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign b_cmd     = sws_pkg::cmd_t'(mid_rd_data[MID_W-1 -: CMD_W]);
    assign b_wr_addr = mid_rd_data[SAMPLE_WIDTH + 2*AW - 1 -: AW];
    assign b_rd_addr = mid_rd_data[SAMPLE_WIDTH + AW - 1 -: AW];
    assign b_sample  = mid_rd_data[SAMPLE_WIDTH-1:0];

    // back end: ring and running sum
    sws_back #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .q_empty   (mid_empty),
        .q_pop     (mid_pop),
        .q_cmd     (b_cmd),
        .q_wr_addr (b_wr_addr),
        .q_rd_addr (b_rd_addr),
        .q_sample  (b_sample),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_sum   (res_sum),
        .res_valid (res_valid)
    );

    // result queue
    assign res_wr_data = {res_valid, res_sum};

    sws_queue #(
        .WIDTH (RES_W),
        .DEPTH (sws_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result_valid = res_rd_data[RES_W-1];
    assign window_sum   = res_rd_data[sws_pkg::SUM_W-1:0];

endmodule

@@ hw/rtl/sws_checker.sv @@
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks of the sliding window sum: transfer bookkeeping, idle
// readiness, reset behavior and result hold under stall.
// ----------------------------------------------------------------------------
module sws_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [sws_pkg::SUM_W-1:0]     window_sum,
    input logic                          result_valid
);

    logic [7:0] outstanding_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    // items accepted whose results are not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // no result without an accepted sample
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == '0 |-> empty)
        else $error("result shown with no sample outstanding");

    // an idle block takes input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == '0 |-> !full)
        else $error("input blocked while idle");

    // reset leaves nothing to pop
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(window_sum) && $stable(result_valid))
        else $error("result changed while stalled");

endmodule

bind sliding_window_sum sws_checker u_sws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .window_sum   (window_sum),
    .result_valid (result_valid)
);
